### rtl/strt_pkg.sv
// Shared types, constants and row-packing helpers for the sorted timestamp row table.
// Depends on nothing; every other file of the block but strt_ram imports it.
package strt_pkg;

  localparam int ROWS      = 64;
  localparam int DATA_COLS = 7;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CNT_W     = $clog2(ROWS + 1);
  localparam int COL_W     = 3;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CELL_W    = VAL_W + 1;
  localparam int ROW_DW    = KEY_W + DATA_COLS * CELL_W;

  localparam logic [2:0] CMD_UPSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_LIST   = 3'd3;
  localparam logic [2:0] CMD_STATUS = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_RANGE     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_UPSERT, OP_DELETE, OP_LOOKUP, OP_LIST, OP_STATUS, OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              col_bad;
    logic [KEY_W-1:0]  key;
    logic [COL_W-1:0]  column;
    logic [VAL_W-1:0]  value;
    logic [6:0]        start_index;
    logic [ROW_W-1:0]  end_index;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ROW_W-1:0]  row_index;
    logic [KEY_W-1:0]  key_out;
    logic [COL_W-1:0]  column_out;
    logic [VAL_W-1:0]  value_out;
    logic              value_valid;
    logic [CNT_W-1:0]  row_total;
    logic              last;
  } out_t;

  function automatic out_t mk_out(status_t st, logic [CNT_W-1:0] row, logic [KEY_W-1:0] key,
                                  logic [COL_W-1:0] col, logic [VAL_W-1:0] val,
                                  logic valid, logic [CNT_W-1:0] total, logic last);
    out_t o;
    o.status      = st;
    o.row_index   = row[ROW_W-1:0];
    o.key_out     = key;
    o.column_out  = col;
    o.value_out   = val;
    o.value_valid = valid;
    o.row_total   = total;
    o.last        = last;
    return o;
  endfunction

  function automatic logic [VAL_W-1:0] cell_val(logic [ROW_DW-1:0] row, logic [COL_W-1:0] c);
    return row[KEY_W + int'(c) * CELL_W +: VAL_W];
  endfunction

  function automatic logic cell_fill(logic [ROW_DW-1:0] row, logic [COL_W-1:0] c);
    return row[KEY_W + int'(c) * CELL_W + VAL_W];
  endfunction

endpackage

### rtl/sorted_timestamp_row_table.sv
// Top level of the sorted timestamp row table.
// Depends on strt_pkg, strt_front and strt_back.
//
// A command beat is taken at a rising edge with start high and busy low. The front end
// decodes it into a two-entry queue; busy rises only while that queue is full, so up to
// two commands can wait while the back end works on a third.
// The back end owns one row memory (key plus all cells of a row in one word) and runs
// each command as a sequence of memory reads and writes. Each result beat appears on
// the out_ ports for exactly one cycle with out_valid high; the receiver cannot stall,
// so beats simply stream out, one per cycle where the command allows.
// Steps per command, after the back end picks it up:
//   lookup and upsert search the keys, a read and a compare per row, up to the match;
//   an insert then shifts the rows above it, a read and a write per row;
//   a range delete moves the tail down, a read and a write per row;
//   list reads and emits each row listed; status reads and emits the first and last row.
// Worst case is an insert into a nearly full table: the search up to the insert point
// and the shift of the rows above it together touch every row in use;
// the registered read port of the row memory makes each row a read step and a second step.
// A synchronous reset empties the table and the queue; memory contents are kept but
// only rows below the row count are ever read.
module sorted_timestamp_row_table import strt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_cmd,
  input  logic [KEY_W-1:0] in_key,
  input  logic [COL_W-1:0] in_column,
  input  logic [VAL_W-1:0] in_value,
  input  logic [6:0]       in_start_index,
  input  logic [ROW_W-1:0] in_end_index,
  input  logic [CNT_W-1:0] in_count,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [ROW_W-1:0] out_row_index,
  output logic [KEY_W-1:0] out_key_out,
  output logic [COL_W-1:0] out_column_out,
  output logic [VAL_W-1:0] out_value_out,
  output logic             out_value_valid,
  output logic [CNT_W-1:0] out_row_total,
  output logic             out_last
);

  logic q_valid, q_pop;
  cmd_t q_item;
  out_t res;

  // Front end: handshake, decode and the command queue.
  strt_front u_front (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_key, .in_column, .in_value,
    .in_start_index, .in_end_index, .in_count, .q_valid, .q_item, .q_pop
  );

  // Back end: search, shift and read out of the row memory.
  strt_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .out_valid, .out_data(res)
  );

  assign out_status      = res.status;
  assign out_row_index   = res.row_index;
  assign out_key_out     = res.key_out;
  assign out_column_out  = res.column_out;
  assign out_value_out   = res.value_out;
  assign out_value_valid = res.value_valid;
  assign out_row_total   = res.row_total;
  assign out_last        = res.last;

endmodule

### rtl/strt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module strt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/strt_front.sv
// Command front end: accepts beats, decodes the command and queues it for the back end.
// Depends on strt_pkg.
module strt_front import strt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_cmd,
  input  logic [KEY_W-1:0] in_key,
  input  logic [COL_W-1:0] in_column,
  input  logic [VAL_W-1:0] in_value,
  input  logic [6:0]       in_start_index,
  input  logic [ROW_W-1:0] in_end_index,
  input  logic [CNT_W-1:0] in_count,
  output logic             q_valid,
  output cmd_t             q_item,
  input  logic             q_pop
);

  cmd_t       ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;
  logic       push;
  cmd_t       dec;

  assign busy    = (fill_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill_r != 2'd0);
  assign q_item  = ent_r[rptr_r];

  always_comb begin
    dec.key         = in_key;
    dec.column      = in_column;
    dec.value       = in_value;
    dec.start_index = in_start_index;
    dec.end_index   = in_end_index;
    dec.count       = in_count;
    dec.col_bad     = (32'(in_column) >= 32'(DATA_COLS));
    unique case (in_cmd)
      CMD_UPSERT: dec.op = OP_UPSERT;
      CMD_DELETE: dec.op = OP_DELETE;
      CMD_LOOKUP: dec.op = OP_LOOKUP;
      CMD_LIST:   dec.op = OP_LIST;
      CMD_STATUS: dec.op = OP_STATUS;
      default:    dec.op = OP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (q_pop) begin
        rptr_r <= !rptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### rtl/strt_back.sv
// Command back end: searches, shifts and reads the row memory and emits result beats.
// Depends on strt_pkg and strt_ram.
module strt_back import strt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_item,
  output logic q_pop,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH, S_CMP, S_DECIDE, S_LOOK, S_UPSH_RD, S_UPSH_WR, S_UPWR,
    S_DSH_RD, S_DSH_WR, S_LRD, S_LEMIT, S_STRD0, S_STEM0, S_STRD1
  } state_t;

  state_t             state_r;
  cmd_t               cur_r;
  logic [CNT_W-1:0]   i_r, d_r, pos_r, rows_r;
  logic               found_r;
  logic [ROW_DW-1:0]  row_r;
  logic [COL_W-1:0]   col_r;
  out_t               out_r;
  logic               out_valid_r;

  logic               we, re;
  logic [ROW_W-1:0]   waddr, raddr;
  logic [ROW_DW-1:0]  wdata, rdata, new_row;
  logic [CNT_W-1:0]   s_u, i_dec;
  logic               s_neg, s_last, del_bad, list_bad;

  strt_ram #(.WIDTH(ROW_DW), .DEPTH(ROWS)) u_rows (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign i_dec     = i_r - 1'b1;

  assign s_neg    = cur_r.start_index[6];
  assign s_last   = (cur_r.start_index == 7'h7F);
  assign s_u      = {1'b0, cur_r.start_index[ROW_W-1:0]};
  assign del_bad  = s_neg || (s_u >= rows_r) ||
                    (({1'b0, s_u} + {1'b0, cur_r.count}) > {1'b0, rows_r});
  assign list_bad = s_neg || (s_u > {1'b0, cur_r.end_index}) ||
                    ({1'b0, cur_r.end_index} >= rows_r);

  always_comb begin
    new_row = row_r;
    new_row[KEY_W-1:0] = cur_r.key;
    new_row[KEY_W + int'(cur_r.column) * CELL_W +: CELL_W] = {1'b1, cur_r.value};
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = i_r[ROW_W-1:0];
    raddr = i_r[ROW_W-1:0];
    wdata = rdata;
    unique case (state_r)
      S_SRCH:    re = (i_r < rows_r);
      S_UPSH_RD: begin
        re    = 1'b1;
        raddr = i_dec[ROW_W-1:0];
      end
      S_UPSH_WR: we = 1'b1;
      S_UPWR:    begin
        we    = 1'b1;
        waddr = pos_r[ROW_W-1:0];
        wdata = new_row;
      end
      S_DSH_RD:  re = (i_r < rows_r);
      S_DSH_WR:  begin
        we    = 1'b1;
        waddr = d_r[ROW_W-1:0];
      end
      S_LRD:     re = 1'b1;
      S_STRD0:   begin
        re    = 1'b1;
        raddr = '0;
      end
      S_STRD1:   begin
        re    = 1'b1;
        raddr = ROW_W'(rows_r - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_item;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          i_r     <= '0;
          state_r <= S_IDLE;
          unique case (cur_r.op)
            OP_UPSERT: begin
              if (cur_r.col_bad) begin
                out_valid_r <= 1'b1;
                out_r <= mk_out(ST_RANGE, '0, cur_r.key, cur_r.column, '0, 1'b0, rows_r, 1'b1);
              end else begin
                state_r <= S_SRCH;
              end
            end
            OP_LOOKUP: state_r <= S_SRCH;
            OP_DELETE: begin
              if (s_last) begin
                out_valid_r <= 1'b1;
                if (rows_r == '0) begin
                  out_r <= mk_out(ST_EMPTY, '0, '0, '0, '0, 1'b0, rows_r, 1'b1);
                end else begin
                  rows_r <= rows_r - 1'b1;
                  out_r  <= mk_out(ST_OK, rows_r - 1'b1, '0, '0, '0, 1'b0,
                                   rows_r - 1'b1, 1'b1);
                end
              end else if (del_bad) begin
                out_valid_r <= 1'b1;
                out_r <= mk_out(ST_RANGE, '0, '0, '0, '0, 1'b0, rows_r, 1'b1);
              end else if (cur_r.count == '0) begin
                out_valid_r <= 1'b1;
                out_r <= mk_out(ST_OK, s_u, '0, '0, '0, 1'b0, rows_r, 1'b1);
              end else begin
                i_r     <= s_u + cur_r.count;
                d_r     <= s_u;
                state_r <= S_DSH_RD;
              end
            end
            OP_LIST: begin
              if (list_bad) begin
                out_valid_r <= 1'b1;
                out_r <= mk_out(ST_RANGE, '0, '0, '0, '0, 1'b0, rows_r, 1'b1);
              end else begin
                i_r     <= s_u;
                state_r <= S_LRD;
              end
            end
            OP_STATUS: begin
              if (rows_r == '0) begin
                out_valid_r <= 1'b1;
                out_r <= mk_out(ST_EMPTY, '0, '0, '0, '0, 1'b0, rows_r, 1'b1);
              end else begin
                state_r <= S_STRD0;
              end
            end
            default: begin
              out_valid_r <= 1'b1;
              out_r <= mk_out(ST_RANGE, '0, '0, '0, '0, 1'b0, rows_r, 1'b1);
            end
          endcase
        end
        S_SRCH: begin
          if (i_r >= rows_r) begin
            pos_r   <= i_r;
            found_r <= 1'b0;
            row_r   <= '0;
            state_r <= S_DECIDE;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata[KEY_W-1:0] >= cur_r.key) begin
            pos_r   <= i_r;
            found_r <= (rdata[KEY_W-1:0] == cur_r.key);
            row_r   <= (rdata[KEY_W-1:0] == cur_r.key) ? rdata : '0;
            state_r <= S_DECIDE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_DECIDE: begin
          col_r <= '0;
          if (cur_r.op == OP_LOOKUP) begin
            if (found_r) begin
              state_r <= S_LOOK;
            end else begin
              out_valid_r <= 1'b1;
              out_r <= mk_out(ST_NOT_FOUND, '0, cur_r.key, '0, '0, 1'b0, rows_r, 1'b1);
              state_r <= S_IDLE;
            end
          end else if (found_r) begin
            state_r <= S_UPWR;
          end else if (rows_r == CNT_W'(ROWS)) begin
            out_valid_r <= 1'b1;
            out_r <= mk_out(ST_FULL, '0, cur_r.key, cur_r.column, '0, 1'b0, rows_r, 1'b1);
            state_r <= S_IDLE;
          end else begin
            i_r     <= rows_r;
            state_r <= (rows_r > pos_r) ? S_UPSH_RD : S_UPWR;
          end
        end
        S_LOOK: begin
          out_valid_r <= 1'b1;
          out_r <= mk_out(ST_OK, pos_r, cur_r.key, col_r, cell_val(row_r, col_r),
                          cell_fill(row_r, col_r), rows_r,
                          32'(col_r) == 32'(DATA_COLS - 1));
          col_r <= col_r + 1'b1;
          if (32'(col_r) == 32'(DATA_COLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_UPSH_RD: state_r <= S_UPSH_WR;
        S_UPSH_WR: begin
          i_r     <= i_dec;
          state_r <= (i_dec > pos_r) ? S_UPSH_RD : S_UPWR;
        end
        S_UPWR: begin
          rows_r      <= rows_r + CNT_W'(!found_r);
          out_valid_r <= 1'b1;
          out_r <= mk_out(ST_OK, pos_r, cur_r.key, cur_r.column, cur_r.value, 1'b1,
                          rows_r + CNT_W'(!found_r), 1'b1);
          state_r <= S_IDLE;
        end
        S_DSH_RD: begin
          if (i_r >= rows_r) begin
            rows_r      <= rows_r - cur_r.count;
            out_valid_r <= 1'b1;
            out_r <= mk_out(ST_OK, s_u, '0, '0, '0, 1'b0, rows_r - cur_r.count, 1'b1);
            state_r <= S_IDLE;
          end else begin
            state_r <= S_DSH_WR;
          end
        end
        S_DSH_WR: begin
          i_r     <= i_r + 1'b1;
          d_r     <= d_r + 1'b1;
          state_r <= S_DSH_RD;
        end
        S_LRD: state_r <= S_LEMIT;
        S_LEMIT: begin
          out_valid_r <= 1'b1;
          out_r <= mk_out(ST_OK, i_r, rdata[KEY_W-1:0], '0, '0, 1'b0, rows_r,
                          i_r == {1'b0, cur_r.end_index});
          i_r     <= i_r + 1'b1;
          state_r <= (i_r == {1'b0, cur_r.end_index}) ? S_IDLE : S_LRD;
        end
        S_STRD0: state_r <= S_STEM0;
        S_STEM0: begin
          out_valid_r <= 1'b1;
          out_r   <= mk_out(ST_OK, '0, rdata[KEY_W-1:0], '0, '0, 1'b0, rows_r, 1'b0);
          state_r <= S_STRD1;
        end
        S_STRD1: begin
          i_r     <= rows_r - 1'b1;
          state_r <= S_LEMIT;
          cur_r.end_index <= ROW_W'(rows_r - 1'b1);
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/strt_checker.sv
// Port-level checks for the sorted timestamp row table, bound to the top level.
// Depends on strt_pkg and sorted_timestamp_row_table.
module strt_checker import strt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_valid,
  input logic [2:0]       out_status,
  input logic [CNT_W-1:0] out_row_total,
  input logic             out_last
);

  // Every error answer is a single beat.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error result not marked last");

  // An empty answer comes only from an empty table.
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_row_total == '0))
    else $error("empty status with rows in use");

  // The row count never exceeds the table size.
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_total <= CNT_W'(ROWS)))
    else $error("row total beyond table size");

  // The queue is not full, so busy is low, right after reset.
  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !busy)
    else $error("busy after reset");

endmodule

bind sorted_timestamp_row_table strt_checker u_strt_checker (
  .clk, .rst_n, .busy, .out_valid, .out_status, .out_row_total, .out_last
);
